FILE: rtl/rdp_pkg.sv
// Package for the reverse delay ping-pong block: sample types, field widths
// and the default store depth. No dependencies.
`timescale 1ns / 1ps

package rdp_pkg;

	localparam int unsigned SAMPLE_W            = 16;
	localparam int unsigned KNOB_W              = 16;
	localparam int unsigned LIM_W               = KNOB_W + 2;
	localparam int unsigned STORE_DEPTH_DEFAULT = 262144;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [KNOB_W-1:0]          knob_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
	} sample_pair_t;

endpackage

FILE: rtl/rdp_store.sv
// Single-port synchronous sample memory, read-before-write, registered read data.
// Depends on rdp_pkg for the sample type.
`timescale 1ns / 1ps

module rdp_store #(
	parameter int unsigned DEPTH  = rdp_pkg::STORE_DEPTH_DEFAULT,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [ADDR_W-1:0]    addr,
	input  rdp_pkg::sample_t     wdata,
	output rdp_pkg::sample_t     rdata
);
	import rdp_pkg::*;

	sample_t mem [DEPTH];
	sample_t rdata_q;

	// old word out, new word in, same address
	always_ff @(posedge clk) begin
		if (en) begin
			mem[addr] <= wdata;
			rdata_q   <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/rdp_sweep.sv
// Ping-pong address sequencer and fill mark for the sample memory.
// Depends on rdp_pkg for knob width and limit width.
`timescale 1ns / 1ps

module rdp_sweep #(
	parameter int unsigned DEPTH  = rdp_pkg::STORE_DEPTH_DEFAULT,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  rdp_pkg::knob_t    knob,
	output logic [ADDR_W-1:0] addr,
	output logic              unwritten
);
	import rdp_pkg::*;

	localparam logic [LIM_W-1:0] LimMax = LIM_W'(DEPTH - 1);

	logic [ADDR_W-1:0] addr_q;
	logic              down_q;
	logic [ADDR_W:0]   fill_q;
	logic [LIM_W-1:0]  lim_full;
	logic [LIM_W-1:0]  lim_sat;
	logic [ADDR_W-1:0] lim;

	// (knob+1)*4-1, clipped to the last entry
	assign lim_full = {knob, 2'b11};
	assign lim_sat  = (lim_full > LimMax) ? LimMax : lim_full;
	assign lim      = lim_sat[ADDR_W-1:0];

	// written entries always form [0, fill_q), since the address moves by one
	assign addr      = addr_q;
	assign unwritten = ({1'b0, addr_q} >= fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			down_q <= 1'b0;
			fill_q <= '0;
		end else if (advance) begin
			if ({1'b0, addr_q} == fill_q) begin
				fill_q <= fill_q + 1'b1;
			end
			if (!down_q) begin
				if (addr_q >= lim) begin
					down_q <= 1'b1;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end else begin
				if (addr_q == '0) begin
					down_q <= 1'b0;
				end else begin
					addr_q <= addr_q - 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/rdp_outq.sv
// Two-entry result queue that parts the memory stage from the output channel.
// Depends on rdp_pkg for the sample pair type.
`timescale 1ns / 1ps

module rdp_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rdp_pkg::sample_pair_t push_data,
	output logic                  full,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rdp_pkg::sample_pair_t out_data
);
	import rdp_pkg::*;

	sample_pair_t entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         pop;

	assign full      = count_q[1];
	assign out_valid = (count_q != 2'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/reverse_delay_pingpong.sv
// Reverse delay, ping-pong sweep: left passes through, right comes from the store.
// Results pass the memory stage, then the output queue. Throughput: one transaction
// per cycle unless stalled, set by the single memory port that reads and writes one
// entry per transaction. Reset clears all control state at once; the store reads as
// zero until written, tracked by a fill mark, so no clearing pass.
// Depends on rdp_pkg, rdp_sweep, rdp_store and rdp_outq.
`timescale 1ns / 1ps

module reverse_delay_pingpong #(
	parameter int unsigned STORE_DEPTH = rdp_pkg::STORE_DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_stall,
	input  rdp_pkg::sample_t  left_sample,
	input  rdp_pkg::sample_t  right_sample,
	input  rdp_pkg::knob_t    delay_knob,

	output logic              out_valid,
	input  logic              out_stall,
	output rdp_pkg::sample_t  left_result,
	output rdp_pkg::sample_t  right_result
);
	import rdp_pkg::*;

	localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

	logic              accept;
	logic [ADDR_W-1:0] addr;
	logic              unwritten;
	sample_t           rdata;

	// memory stage: holds the transaction whose store word is on rdata
	logic              valid_s1;
	sample_t           left_s1;
	logic              unwritten_s1;
	logic              move_s1;

	logic              q_full;
	sample_pair_t      q_push_data;
	sample_pair_t      q_out_data;

	// Hold the memory stage only when the result queue is full; the store
	// output is only refreshed on accept, so a held stage keeps its word.
	assign move_s1  = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;

	// Address sequencer: presents the current sweep address and advances
	// along the ping-pong path once per accepted transaction.
	rdp_sweep #(
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.knob      (delay_knob),
		.addr      (addr),
		.unwritten (unwritten)
	);

	// Read the old word and write the new right sample in one access. A
	// repeat of the same address on the next transaction (turnaround) sees
	// the word written here, since the write lands at this edge.
	rdp_store #(
		.DEPTH  (STORE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.en    (accept),
		.addr  (addr),
		.wdata (right_sample),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of the memory stage, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1      <= left_sample;
			unwritten_s1 <= unwritten;
		end
	end

	// Entries never written since reset read as zero.
	assign q_push_data.left  = left_s1;
	assign q_push_data.right = unwritten_s1 ? '0 : rdata;

	// Output queue: takes a finished transaction even while the previous
	// result still waits on a stalled output.
	rdp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (move_s1),
		.push_data (q_push_data),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (q_out_data)
	);

	assign left_result  = q_out_data.left;
	assign right_result = q_out_data.right;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for reverse_delay_pingpong: a queue-fed driver, a mirror of the
// delay store and ping-pong sweep that predicts each result pair, and a checking monitor.
// Depends on rdp_pkg and the reverse_delay_pingpong RTL.
`timescale 1ns / 1ps

module tb;

	import rdp_pkg::*;

	localparam int unsigned DEPTH        = STORE_DEPTH_DEFAULT;
	localparam int unsigned N_RANDOM     = 1100;
	localparam int unsigned HOLD_CYCLES  = 200;   // long receiver hold-off
	localparam int unsigned DRAIN_CYCLES = 16;    // drain margin after the last result
	localparam int unsigned IDLE_LIMIT   = 2000;  // watchdog: cycles with no transaction
	localparam int unsigned PRINT_CAP    = 50;

	// One stereo input transaction as offered to the block
	typedef struct {
		sample_t left;
		sample_t right;
		knob_t   knob;
	} audio_in_t;

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    in_valid     = 1'b0;
	logic    in_stall;
	sample_t left_sample  = '0;
	sample_t right_sample = '0;
	knob_t   delay_knob   = '0;
	logic    out_valid;
	logic    out_stall    = 1'b0;
	sample_t left_result;
	sample_t right_result;

	// Transactions still to be offered, and result pairs still owed by the block
	audio_in_t    tx_backlog[$];
	sample_pair_t due_pairs[$];

	// Mirror of the delay store and of the sweep
	sample_t     tap_mirror [DEPTH];
	int unsigned sweep_pos;
	bit          sweep_falling;

	int unsigned mismatches = 0;

	reverse_delay_pingpong #(
		.STORE_DEPTH(DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.left_sample (left_sample),
		.right_sample(right_sample),
		.delay_knob  (delay_knob),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_result (left_result),
		.right_result(right_result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Read the tap at the sweep position, overwrite it with the new right sample,
	// then step the sweep: bounce at the knob limit going up and at zero going down.
	function automatic void advance_sweep(input audio_in_t it);
		int unsigned  pos;
		int unsigned  limit;
		sample_pair_t owed;
		begin
			pos = sweep_pos;
			if (pos >= DEPTH)
				pos = DEPTH - 1;
			owed.left  = it.left;
			owed.right = tap_mirror[pos];
			tap_mirror[pos] = it.right;

			// limit saturates at the top of the store
			limit = ((int'(it.knob) + 1) << 2) - 1;
			if (limit > DEPTH - 1)
				limit = DEPTH - 1;

			if (!sweep_falling) begin
				// an address above a lowered limit turns the sweep at once
				if (pos >= limit)
					sweep_falling = 1'b1;
				else
					pos++;
			end else begin
				if (pos == 0)
					sweep_falling = 1'b0;
				else
					pos--;
			end
			sweep_pos = pos;
			due_pairs.push_back(owed);
		end
	endfunction

	task automatic report_mismatch(input string what);
		begin
			if (mismatches < PRINT_CAP)
				$display("%0t ns: mismatch: %s", $time, what);
			mismatches++;
		end
	endtask

	task automatic queue_item(input sample_t l, input sample_t r, input knob_t k);
		audio_in_t it;
		begin
			it.left  = l;
			it.right = r;
			it.knob  = k;
			tx_backlog.push_back(it);
		end
	endtask

	// Driver: offer transactions in bursts with gaps, hold the payload while stalled,
	// and twice pause until every owed result has come back.
	audio_in_t   offer;
	int unsigned n_accepted = 0;
	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;
	bit          draining   = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				advance_sweep(offer);
				n_accepted++;
				if (n_accepted == 300 || n_accepted == 900)
					draining = 1'b1;
			end
			if (!in_valid || !in_stall) begin
				if (draining && due_pairs.size() == 0)
					draining = 1'b0;
				if (draining || gap_left != 0 || tx_backlog.size() == 0) begin
					if (!draining && gap_left != 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					offer = tx_backlog.pop_front();
					in_valid     <= 1'b1;
					left_sample  <= offer.left;
					right_sample <= offer.right;
					delay_knob   <= offer.knob;
					burst_left--;
					if (burst_left == 0) begin
						// a quarter of bursts run straight into the next one
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
						burst_left = $urandom_range(1, 40);
					end
				end
			end
		end
	end

	// Receiver: stall on a pattern of its own, with two long hold-offs that let the
	// block fill up and push back on its input.
	rx_mode_t    rx_mode    = RX_FREE;
	int unsigned mode_left  = 0;
	int unsigned hold_left  = 0;
	int unsigned holds_done = 0;
	int unsigned rx_seen    = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				rx_seen++;
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if ((holds_done == 0 && rx_seen >= 350) ||
				(holds_done == 1 && rx_seen >= 800)) begin
				holds_done++;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					case ($urandom_range(0, 2))
						0: begin
							rx_mode = RX_FREE;
						end
						1: begin
							rx_mode = RX_LIGHT;
						end
						default: begin
							rx_mode = RX_HEAVY;
						end
					endcase
					mode_left = $urandom_range(20, 150);
				end else begin
					mode_left--;
				end
				case (rx_mode)
					RX_FREE: begin
						out_stall <= 1'b0;
					end
					RX_LIGHT: begin
						out_stall <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						out_stall <= ($urandom_range(0, 3) != 0);
					end
				endcase
			end
		end
	end

	// Monitor: check every accepted result pair against the oldest one owed
	always @(posedge clk) begin
		sample_pair_t owed;
		if (arst_n && out_valid && !out_stall) begin
			if (due_pairs.size() == 0) begin
				report_mismatch($sformatf("unexpected result left=%h right=%h",
					left_result, right_result));
			end else begin
				owed = due_pairs.pop_front();
				if (left_result !== owed.left)
					report_mismatch($sformatf("left_result got %h want %h",
						left_result, owed.left));
				if (right_result !== owed.right)
					report_mismatch($sformatf("right_result got %h want %h",
						right_result, owed.right));
			end
		end
	end

	// Watchdog: end the run if nothing moves on either side for too long
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("** reverse_delay_pingpong: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n_made;
		int unsigned seg_len;
		knob_t       seg_knob;
		knob_t       k;
		sample_t     l;
		sample_t     r;

		foreach (tap_mirror[i])
			tap_mirror[i] = '0;
		sweep_pos     = 0;
		sweep_falling = 1'b0;

		// Directed: sample extremes against an empty store at the smallest knob
		queue_item(16'sh7FFF, 16'sh8000, 16'd0);
		queue_item(16'sh8000, 16'sh7FFF, 16'd0);
		queue_item(16'sh0000, 16'shFFFF, 16'd0);
		queue_item(16'shFFFF, 16'sh0001, 16'd0);
		// bounce at the top, then walk back down and read the taps reversed
		queue_item(16'sh5555, 16'shAAAA, 16'd0);
		queue_item(16'shAAAA, 16'sh5555, 16'd0);
		queue_item(16'sh0001, 16'sh1234, 16'd0);
		queue_item(16'sh1234, 16'shFEDC, 16'd0);
		// largest knob: limit reaches the last word of the store
		queue_item(16'sh7FFF, 16'sh7FFF, 16'hFFFF);
		queue_item(16'sh8000, 16'sh8000, 16'hFFFF);
		queue_item(16'shFFFF, 16'sh0000, 16'hFFFF);
		// climb under a mid knob, then lower it mid-sweep so the sweep turns at once
		for (int i = 0; i < 10; i++)
			queue_item(sample_t'($urandom), sample_t'($urandom), 16'd3);
		queue_item(16'sh0F0F, 16'shF0F0, 16'd0);
		queue_item(16'shF0F0, 16'sh0F0F, 16'd0);
		queue_item(16'sh3C3C, 16'shC3C3, 16'd0);

		// Random: segments of steady knob with some per-transaction knob noise
		n_made = 0;
		while (n_made < N_RANDOM) begin
			seg_len = $urandom_range(4, 60);
			case ($urandom_range(0, 9))
				0: begin
					seg_knob = knob_t'($urandom);
				end
				1, 2: begin
					seg_knob = knob_t'($urandom_range(16, 63));
				end
				default: begin
					seg_knob = knob_t'($urandom_range(0, 15));
				end
			endcase
			for (int i = 0; i < seg_len; i++) begin
				k = seg_knob;
				if ($urandom_range(0, 9) == 0)
					k = knob_t'($urandom_range(0, 15));
				else if ($urandom_range(0, 39) == 0)
					k = knob_t'($urandom);
				l = sample_t'($urandom);
				r = sample_t'($urandom);
				if ($urandom_range(0, 15) == 0)
					l = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				if ($urandom_range(0, 15) == 0)
					r = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				queue_item(l, r, k);
				n_made++;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the backlog to empty and every owed pair to arrive, then settle
		while (tx_backlog.size() != 0 || in_valid || due_pairs.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && due_pairs.size() == 0)
			$display("** reverse_delay_pingpong: PASSED **");
		else
			$display("** reverse_delay_pingpong: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
rtl/rdp_pkg.sv
rtl/rdp_store.sv
rtl/rdp_sweep.sv
rtl/rdp_outq.sv
rtl/reverse_delay_pingpong.sv
tb/tb.sv
